// ===== rtl/bdt_pkg.sv =====
package bdt_pkg;

    // Fixed field widths of the input and result words
    localparam int STATE_W = 10;
    localparam int SLOT_W  = 4;
    localparam int WSEL_W  = 2;
    localparam int WORD_W  = 64;
    localparam int COUNT_W = 5;
    localparam int BYTE_W  = 8;
    localparam int BIT_W   = 6;

    typedef enum logic [1:0] {
        ACT_WR_BITMAP = 2'd0,
        ACT_WR_TARGET = 2'd1,
        ACT_WR_COUNT  = 2'd2,
        ACT_STEP      = 2'd3
    } action_t;

    typedef struct packed {
        action_t              action;
        logic [STATE_W-1:0]   state_index;
        logic [SLOT_W-1:0]    edge_slot;
        logic [WSEL_W-1:0]    word_index;
        logic [WORD_W-1:0]    bitmap_word;
        logic [STATE_W-1:0]   target_state;
        logic [COUNT_W-1:0]   edge_count;
        logic [BYTE_W-1:0]    input_byte;
    } in_word_t;

    typedef struct packed {
        logic [STATE_W-1:0]   next_state;
        logic                 matched;
    } out_word_t;

endpackage

// ===== rtl/bitmap_dfa_transition_lookup.sv =====
// Write words (bitmap, target, count) are accepted back to back.
// A step word examines the state's edges (up to 16) in slot order until the first match;
// one edge is examined per cycle through the registered bitmap/target memory read ports.
// A new step is accepted in the cycle after its result is loaded, and the finished result
// first waits for the output register to empty.
// After reset the edge count memory is cleared, one entry per cycle (MAX_STATES capped at 1024).
module bitmap_dfa_transition_lookup
    import bdt_pkg::*;
#(
    parameter int MAX_STATES = 1024,
    parameter int MAX_EDGES  = 16,
    parameter int ALPHABET   = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    // No word is accepted during the clear pass.
    // Reachable states and slots are bounded by the field widths
    localparam int NS       = (MAX_STATES < (1 << STATE_W)) ? MAX_STATES : (1 << STATE_W);
    localparam int NE       = (MAX_EDGES < (1 << SLOT_W)) ? MAX_EDGES : (1 << SLOT_W);
    localparam int BMW      = (ALPHABET + WORD_W - 1) / WORD_W;
    localparam int BM_DEPTH = NS * NE * BMW;
    localparam int TG_DEPTH = NS * NE;
    localparam int BM_AW    = $clog2(BM_DEPTH);
    localparam int TG_AW    = $clog2(TG_DEPTH);
    localparam int CNT_AW   = $clog2(NS);
    localparam int CW       = $clog2(NE + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [CNT_AW-1:0]   clr_idx_reg;
    logic [STATE_W-1:0]  st_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [CW-1:0]       edge_reg;
    logic                chk_valid_reg;
    out_word_t           res_reg;
    logic                m_valid_reg;
    out_word_t           m_data_reg;

    logic [WORD_W-1:0]   bm_mem_reg [BM_DEPTH];
    logic [STATE_W-1:0]  tg_mem_reg [TG_DEPTH];
    logic [CW-1:0]       cnt_mem_reg [NS];
    logic [WORD_W-1:0]   bm_rd_reg;
    logic [STATE_W-1:0]  tg_rd_reg;
    logic [CW-1:0]       cnt_rd_reg;

    logic                acc;
    logic                st_ok;
    logic                slot_ok;
    logic                word_ok;
    logic                byte_ok;
    logic                bm_we;
    logic                tg_we;
    logic                cnt_we;
    logic                cnt_re;
    logic [BM_AW-1:0]    bm_waddr;
    logic [BM_AW-1:0]    bm_raddr;
    logic [TG_AW-1:0]    tg_waddr;
    logic [TG_AW-1:0]    tg_raddr;
    logic [CNT_AW-1:0]   cnt_waddr;
    logic [CW-1:0]       cnt_wdata;
    logic [CW-1:0]       cnt_clip;
    logic                issue;
    logic                hit;
    logic                out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign acc      = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Range checks on the incoming word
    assign st_ok   = int'(s_data.state_index) < NS;
    assign slot_ok = int'(s_data.edge_slot) < NE;
    assign word_ok = int'(s_data.word_index) < BMW;
    assign byte_ok = int'(s_data.input_byte) < ALPHABET;

    // Write side addressing
    always_comb begin
        bm_waddr = BM_AW'((int'(s_data.state_index) * NE + int'(s_data.edge_slot)) * BMW
                          + int'(s_data.word_index));
        tg_waddr = TG_AW'(int'(s_data.state_index) * NE + int'(s_data.edge_slot));
        cnt_clip = (int'(s_data.edge_count) > NE) ? CW'(NE) : CW'(s_data.edge_count);
        bm_we    = acc && (s_data.action == ACT_WR_BITMAP) && st_ok && slot_ok && word_ok;
        tg_we    = acc && (s_data.action == ACT_WR_TARGET) && st_ok && slot_ok;
        cnt_re   = acc && (s_data.action == ACT_STEP);
        if (state_reg == S_CLEAR) begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_idx_reg;
            cnt_wdata = '0;
        end else begin
            cnt_we    = acc && (s_data.action == ACT_WR_COUNT) && st_ok;
            cnt_waddr = CNT_AW'(s_data.state_index);
            cnt_wdata = cnt_clip;
        end
    end

    // Scan side addressing: one edge issued per cycle, checked the cycle after
    always_comb begin
        bm_raddr = BM_AW'((int'(st_reg) * NE + int'(edge_reg)) * BMW
                          + int'(byte_reg[BYTE_W-1:BIT_W]));
        tg_raddr = TG_AW'(int'(st_reg) * NE + int'(edge_reg));
        issue    = edge_reg < cnt_rd_reg;
        hit      = chk_valid_reg && bm_rd_reg[byte_reg[BIT_W-1:0]];
    end

    // Bitmap memory
    always_ff @(posedge aclk) begin
        if (bm_we) begin
            bm_mem_reg[bm_waddr] <= s_data.bitmap_word;
        end
        bm_rd_reg <= bm_mem_reg[bm_raddr];
    end

    // Target memory
    always_ff @(posedge aclk) begin
        if (tg_we) begin
            tg_mem_reg[tg_waddr] <= s_data.target_state;
        end
        tg_rd_reg <= tg_mem_reg[tg_raddr];
    end

    // Edge count memory; read once per step and held through the scan
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem_reg[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            cnt_rd_reg <= cnt_mem_reg[CNT_AW'(s_data.state_index)];
        end
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            chk_valid_reg <= 1'b0;
            edge_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // load a finished result, or drop the one just taken
            if ((state_reg == S_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == CNT_AW'(NS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc && (s_data.action == ACT_STEP)) begin
                        st_reg        <= s_data.state_index;
                        byte_reg      <= s_data.input_byte;
                        edge_reg      <= '0;
                        chk_valid_reg <= 1'b0;
                        res_reg       <= '0;
                        state_reg     <= (st_ok && byte_ok) ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN: begin
                    priority if (hit) begin
                        res_reg.next_state <= tg_rd_reg;
                        res_reg.matched    <= 1'b1;
                        chk_valid_reg      <= 1'b0;
                        state_reg          <= S_DONE;
                    end else if (!issue) begin
                        chk_valid_reg <= 1'b0;
                        state_reg     <= S_DONE;
                    end else begin
                        edge_reg      <= edge_reg + 1'b1;
                        chk_valid_reg <= 1'b1;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        m_data_reg <= res_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.matched) |-> (m_data.next_state == '0))
        else $error("miss result carries a nonzero next state");

    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.action == ACT_STEP)) |=> !s_ready)
        else $error("new word accepted right after a step");

    a_edge_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (edge_reg <= cnt_rd_reg))
        else $error("scan ran past the edge count");
`endif

endmodule
